/* design/lottery_scheduler_defines.svh */
// Assertion macros shared by the lottery scheduler checker.
`ifndef LOTTERY_SCHEDULER_DEFINES_SVH
`define LOTTERY_SCHEDULER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock and off during reset.
`define LSCHED_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock and off during reset.
`define LSCHED_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/lsched_pkg.sv */
// Package with types, constants and defaults of the lottery scheduler.
package lsched_pkg;

  // Default size of the slot table.
  localparam int NUM_SLOTS_DEF = 64;

  // Fixed field widths.
  localparam int SLOT_W   = 6;
  localparam int TICKET_W = 16;
  localparam int MASK_W   = 64;
  localparam int LCG_W    = 32;

  // Generator constants and reset values.
  localparam logic [LCG_W-1:0]    LCG_MUL        = 32'd1664525;
  localparam logic [LCG_W-1:0]    LCG_ADD        = 32'd1013904223;
  localparam logic [LCG_W-1:0]    LCG_SEED       = 32'd123456;
  localparam logic [TICKET_W-1:0] TICKETS_RESET  = 16'd100;

  // Width of the remainder step counter; there is one step per generator bit.
  localparam int DIV_CNT_W = $clog2(LCG_W + 1);

  // Input operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_DRAW  = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SUM,
    ST_LCG,
    ST_DIV_INIT,
    ST_DIV,
    ST_WALK,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;      // capture the input word and clear accumulators
    logic wr_table;   // write the latched ticket count
    logic scan_clr;   // restart the slot scan
    logic scan_run;   // advance the slot scan
    logic walk_mode;  // scan looks for the winner instead of summing
    logic lcg_step;   // advance the generator
    logic div_start;  // load the remainder unit
    logic div_run;    // one remainder step
    logic load_out;   // move the result into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic total_zero;
    logic div_done;
  } dp_sts_t;

endpackage

/* design/lottery_scheduler.sv */
// Lottery scheduler top level: picks a runnable slot with odds in proportion to
// its tickets. One word is taken at a time. A ticket write passes through the
// write and done states to its result word. In a draw the ticket table sits in
// a RAM with one read port, so the sum over the runnable slots and the winner
// walk each read one slot a cycle, and the remainder of the 32-bit generator
// value by the ticket sum takes one step per bit. A draw with a zero sum skips
// the generator, remainder and walk. A finished result waits in the output
// register while the next word is taken.
module lottery_scheduler #(
  parameter int NumSlots = lsched_pkg::NUM_SLOTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            op_i,
  input  logic [lsched_pkg::SLOT_W-1:0]   slot_i,
  input  logic [lsched_pkg::TICKET_W-1:0] ticket_count_i,
  input  logic [lsched_pkg::MASK_W-1:0]   runnable_mask_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            found_o,
  output logic [lsched_pkg::SLOT_W-1:0]   winner_slot_o
);

  lsched_pkg::dp_cmd_t cmd;
  lsched_pkg::dp_sts_t sts;

  // Sequencer.
  lsched_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Table, generator and arithmetic.
  lsched_dp #(
    .NumSlots (NumSlots)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op_i),
    .slot_i          (slot_i),
    .ticket_count_i  (ticket_count_i),
    .runnable_mask_i (runnable_mask_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .found_o         (found_o),
    .winner_slot_o   (winner_slot_o)
  );

endmodule

/* design/lsched_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lsched_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/lsched_ctrl.sv */
// Controller state machine of the lottery scheduler.
module lsched_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 op_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  lsched_pkg::dp_sts_t  sts_i,
  output lsched_pkg::dp_cmd_t  cmd_o
);

  lsched_pkg::state_e state_q, state_d;
  logic               out_valid_q, out_valid_d;

  // State and output valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lsched_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != lsched_pkg::ST_IDLE);
    unique case (state_q)
      lsched_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch    = 1'b1;
          cmd_o.scan_clr = 1'b1;
          state_d = (op_i == lsched_pkg::OP_DRAW) ? lsched_pkg::ST_SUM
                                                  : lsched_pkg::ST_WRITE;
        end
      end
      lsched_pkg::ST_WRITE: begin
        cmd_o.wr_table = 1'b1;
        state_d = lsched_pkg::ST_DONE;
      end
      lsched_pkg::ST_SUM: begin
        if (sts_i.scan_done) begin
          state_d = sts_i.total_zero ? lsched_pkg::ST_DONE : lsched_pkg::ST_LCG;
        end else begin
          cmd_o.scan_run = 1'b1;
        end
      end
      lsched_pkg::ST_LCG: begin
        cmd_o.lcg_step = 1'b1;
        state_d = lsched_pkg::ST_DIV_INIT;
      end
      lsched_pkg::ST_DIV_INIT: begin
        cmd_o.div_start = 1'b1;
        state_d = lsched_pkg::ST_DIV;
      end
      lsched_pkg::ST_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.scan_clr = 1'b1;
          state_d = lsched_pkg::ST_WALK;
        end else begin
          cmd_o.div_run = 1'b1;
        end
      end
      lsched_pkg::ST_WALK: begin
        cmd_o.walk_mode = 1'b1;
        if (sts_i.scan_done) begin
          state_d = lsched_pkg::ST_DONE;
        end else begin
          cmd_o.scan_run = 1'b1;
        end
      end
      lsched_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d = lsched_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lsched_pkg::ST_IDLE;
      end
    endcase
  end

  // The output word stays until the consumer takes it.
  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* design/lsched_dp.sv */
// Datapath of the lottery scheduler: ticket table, slot scan, generator, remainder.
module lsched_dp #(
  parameter int NumSlots = lsched_pkg::NUM_SLOTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            op_i,
  input  logic [lsched_pkg::SLOT_W-1:0]   slot_i,
  input  logic [lsched_pkg::TICKET_W-1:0] ticket_count_i,
  input  logic [lsched_pkg::MASK_W-1:0]   runnable_mask_i,
  input  lsched_pkg::dp_cmd_t             cmd_i,
  output lsched_pkg::dp_sts_t             sts_o,
  output logic                            found_o,
  output logic [lsched_pkg::SLOT_W-1:0]   winner_slot_o
);

  localparam int SlotW   = lsched_pkg::SLOT_W;
  localparam int TicketW = lsched_pkg::TICKET_W;
  localparam int LcgW    = lsched_pkg::LCG_W;
  localparam int DivCntW = lsched_pkg::DIV_CNT_W;
  localparam int IdxW    = $clog2(NumSlots);
  localparam int CntW    = $clog2(NumSlots + 1);
  localparam int TotW    = TicketW + IdxW;

  // Latched input word.
  logic                op_q;
  logic [SlotW-1:0]    slot_q;
  logic [TicketW-1:0]  count_q;
  logic [NumSlots-1:0] mask_q;

  // Table bookkeeping: a slot never written reads as the reset count.
  logic [NumSlots-1:0] written_q;
  logic                slot_ok;
  logic [TicketW-1:0]  ram_rdata;

  // Scan issue counter and the stage that meets the RAM read data.
  logic [CntW-1:0]     idx_q;
  logic                issue;
  logic                stg_vld_q;
  logic [IdxW-1:0]     stg_idx_q;
  logic                stg_written_q;
  logic                stg_mask_q;
  logic [TicketW-1:0]  tick;
  logic [TotW-1:0]     add_tick;
  logic [TotW-1:0]     acc_sum;

  // Totals, generator, remainder unit and winner.
  logic [TotW-1:0]     total_q;
  logic [TotW-1:0]     acc_q;
  logic [LcgW-1:0]     lcg_q;
  logic [LcgW-1:0]     quo_q;
  logic [TotW-1:0]     rem_q;
  logic [DivCntW-1:0]  div_cnt_q;
  logic [TotW:0]       rem_sh;
  logic [TotW:0]       rem_diff;
  logic                hit_q;
  logic [IdxW-1:0]     win_q;
  logic                found_q;
  logic [SlotW-1:0]    winner_q;

  assign slot_ok = (32'(slot_q) < NumSlots);
  assign issue   = cmd_i.scan_run && (idx_q < CntW'(NumSlots));

  lsched_ram #(
    .Width (TicketW),
    .Depth (NumSlots)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_table && slot_ok),
    .waddr_i (slot_q[IdxW-1:0]),
    .wdata_i (count_q),
    .raddr_i (idx_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Ticket of the slot in the stage, masked by its runnable bit.
  assign tick     = stg_written_q ? ram_rdata : lsched_pkg::TICKETS_RESET;
  assign add_tick = stg_mask_q ? TotW'(tick) : '0;
  assign acc_sum  = acc_q + add_tick;

  // One restoring remainder step on the next generator bit.
  assign rem_sh   = {rem_q, quo_q[LcgW-1]};
  assign rem_diff = rem_sh - {1'b0, total_q};

  // Input word, held for the whole item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q    <= op_i;
      slot_q  <= slot_i;
      count_q <= ticket_count_i;
      mask_q  <= runnable_mask_i[NumSlots-1:0];
    end
  end

  // Written flags of the table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (cmd_i.wr_table && slot_ok) begin
      written_q[slot_q[IdxW-1:0]] <= 1'b1;
    end
  end

  // Scan counter and stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      stg_vld_q <= 1'b0;
    end else if (cmd_i.scan_clr) begin
      idx_q     <= '0;
      stg_vld_q <= 1'b0;
    end else begin
      stg_vld_q <= issue;
      if (issue) begin
        idx_q <= idx_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      stg_idx_q     <= idx_q[IdxW-1:0];
      stg_written_q <= written_q[idx_q[IdxW-1:0]];
      stg_mask_q    <= mask_q[idx_q[IdxW-1:0]];
    end
  end

  // Ticket sum and the walk for the first slot past the drawn value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (cmd_i.latch) begin
      hit_q <= 1'b0;
    end else if (stg_vld_q && cmd_i.walk_mode && stg_mask_q && !hit_q && (acc_sum > rem_q)) begin
      hit_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      total_q <= '0;
      acc_q   <= '0;
    end else if (stg_vld_q) begin
      if (cmd_i.walk_mode) begin
        acc_q <= acc_sum;
        if (stg_mask_q && !hit_q && (acc_sum > rem_q)) begin
          win_q <= stg_idx_q;
        end
      end else begin
        total_q <= total_q + add_tick;
      end
    end
  end

  // Linear congruential generator.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcg_q <= lsched_pkg::LCG_SEED;
    end else if (cmd_i.lcg_step) begin
      lcg_q <= LcgW'(lcg_q * lsched_pkg::LCG_MUL + lsched_pkg::LCG_ADD);
    end
  end

  // Remainder of the generator value by the ticket total, one bit a cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_run) begin
      div_cnt_q <= div_cnt_q + DivCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      quo_q <= lcg_q;
      rem_q <= '0;
    end else if (cmd_i.div_run) begin
      quo_q <= {quo_q[LcgW-2:0], 1'b0};
      rem_q <= rem_diff[TotW] ? rem_sh[TotW-1:0] : rem_diff[TotW-1:0];
    end
  end

  // Output word register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      found_q  <= hit_q;
      winner_q <= hit_q ? SlotW'(win_q) : '0;
    end
  end

  assign sts_o.scan_done  = (idx_q == CntW'(NumSlots)) && !stg_vld_q;
  assign sts_o.total_zero = (total_q == '0) || (op_q != lsched_pkg::OP_DRAW);
  assign sts_o.div_done   = (div_cnt_q == DivCntW'(LcgW));
  assign found_o          = found_q;
  assign winner_slot_o    = winner_q;

endmodule

/* design/lsched_checker.sv */
// Port-level checker of the lottery scheduler and its bind.
`include "lottery_scheduler_defines.svh"

module lsched_checker #(
  parameter int NumSlots = lsched_pkg::NUM_SLOTS_DEF
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            op_i,
  input logic [lsched_pkg::SLOT_W-1:0]   slot_i,
  input logic [lsched_pkg::TICKET_W-1:0] ticket_count_i,
  input logic [lsched_pkg::MASK_W-1:0]   runnable_mask_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic                            found_o,
  input logic [lsched_pkg::SLOT_W-1:0]   winner_slot_o
);

  // An accepted word keeps the input side stalled while it is worked on.
  `LSCHED_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "input not stalled after accept")

  // A result word with no winner carries slot zero.
  `LSCHED_ASSERT_NOW(a_no_winner_zero, out_valid_o && !found_o, winner_slot_o == '0, "winner slot not zero without winner")

  // A winner always lies inside the table.
  `LSCHED_ASSERT_NOW(a_winner_in_table, out_valid_o && found_o, 32'(winner_slot_o) < NumSlots, "winner outside the table")

  // A stalled result word holds.
  `LSCHED_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(found_o) && $stable(winner_slot_o), "stalled result changed")

endmodule

bind lottery_scheduler lsched_checker #(.NumSlots(NumSlots)) u_checker (.*);
